// ----- src/cbd_pkg.sv -----
// shared types, character codes and helpers for the chunked body decoder
`timescale 1ns / 1ps

package cbd_pkg;

  localparam int SIZE_WIDTH_DEF = 32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic [3:0] {
    PH_LEAD    = 4'd0,
    PH_SIGNED  = 4'd1,
    PH_DIGITS  = 4'd2,
    PH_SKIP    = 4'd3,
    PH_DATA    = 4'd4,
    PH_DATA_CR = 4'd5,
    PH_DATA_LF = 4'd6,
    PH_END_CR  = 4'd7,
    PH_END_LF  = 4'd8,
    PH_DONE    = 4'd9,
    PH_ERR     = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY      = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    status_t    status;
  } cbd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    logic [7:0] v;
    h = '0;
    v = '0;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
      h.ok = 1'b1;
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      v = c - CH_A_LO + HEX_TEN;
      h.ok = 1'b1;
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      v = c - CH_A_UP + HEX_TEN;
      h.ok = 1'b1;
    end
    h.val = v[3:0];
    return h;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ----- src/cbd_parser.sv -----
// chunk framing state and per-word decode step
`timescale 1ns / 1ps

module cbd_parser #(
  parameter int SIZE_WIDTH = cbd_pkg::SIZE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          body_byte,
  input  logic                body_last,
  output cbd_pkg::cbd_result_t result
);
  import cbd_pkg::*;

  typedef struct packed {
    phase_t                phase;
    logic [SIZE_WIDTH-1:0] rem;
    logic                  neg;
    logic                  dseen;
    logic                  hxo;
    logic                  ovf;
    logic                  cp;
  } line_st_t;

  localparam line_st_t ST_RESET = '{phase: PH_LEAD, rem: '0, neg: 1'b0,
                                    dseen: 1'b0, hxo: 1'b0, ovf: 1'b0, cp: 1'b0};

  line_st_t st;
  line_st_t st_next;
  line_st_t work;

  function automatic line_st_t line_char(line_st_t s, logic [7:0] c);
    line_st_t r;
    hex_t     h;
    r = s;
    h = hex_decode(c);
    case (s.phase)
      PH_LEAD, PH_SIGNED: begin
        if (s.phase == PH_LEAD && is_space(c)) begin
          r.phase = PH_LEAD;
        end else if (s.phase == PH_LEAD && c == CH_PLUS) begin
          r.phase = PH_SIGNED;
        end else if (s.phase == PH_LEAD && c == CH_MINUS) begin
          r.neg   = 1'b1;
          r.phase = PH_SIGNED;
        end else if (h.ok) begin
          r.dseen = 1'b1;
          r.rem   = SIZE_WIDTH'(h.val);
          r.hxo   = (h.val == 4'd0);
          r.phase = PH_DIGITS;
        end else begin
          r.phase = PH_SKIP;
        end
      end
      PH_DIGITS: begin
        r.hxo = 1'b0;
        if (s.hxo && (c == CH_X_LO || c == CH_X_UP)) begin
          r.phase = PH_DIGITS;
        end else if (!h.ok) begin
          r.phase = PH_SKIP;
        end else if (s.ovf) begin
          r.ovf = 1'b1;
        end else if (|s.rem[SIZE_WIDTH-1 -: 4]) begin
          // next digit would not fit
          r.ovf = 1'b1;
        end else begin
          r.rem = {s.rem[SIZE_WIDTH-5:0], h.val};
        end
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

  function automatic line_st_t finish_line(line_st_t s);
    line_st_t r;
    logic     bad;
    r   = s;
    bad = !s.dseen || s.ovf || (s.neg && (s.rem != '0));
    if (bad) begin
      r.phase = PH_ERR;
      r.rem   = '0;
    end else if (s.rem == '0) begin
      r.phase = PH_END_CR;
    end else begin
      r.phase = PH_DATA;
    end
    r.neg   = 1'b0;
    r.dseen = 1'b0;
    r.hxo   = 1'b0;
    r.ovf   = 1'b0;
    return r;
  endfunction

  always_comb begin
    work           = st;
    st_next        = st;
    result.valid   = 1'b0;
    result.data    = '0;
    case (st.phase)
      PH_LEAD, PH_SIGNED, PH_DIGITS, PH_SKIP: begin
        work.cp = 1'b0;
        if (st.cp && body_byte == CH_LF) begin
          work = finish_line(work);
        end else begin
          // a lone cr counts as an ordinary line character
          if (st.cp) begin
            work = line_char(work, CH_CR);
          end
          if (body_byte == CH_CR) begin
            work.cp = 1'b1;
          end else begin
            work = line_char(work, body_byte);
          end
        end
        st_next = work;
      end
      PH_DATA: begin
        result.valid = 1'b1;
        result.data  = body_byte;
        st_next.rem  = st.rem - SIZE_WIDTH'(1);
        if (st.rem == SIZE_WIDTH'(1)) begin
          st_next.phase = PH_DATA_CR;
        end
      end
      PH_DATA_CR: st_next.phase = (body_byte == CH_CR) ? PH_DATA_LF : PH_ERR;
      PH_DATA_LF: st_next.phase = (body_byte == CH_LF) ? PH_LEAD : PH_ERR;
      PH_END_CR:  st_next.phase = (body_byte == CH_CR) ? PH_END_LF : PH_ERR;
      PH_END_LF:  st_next.phase = (body_byte == CH_LF) ? PH_DONE : PH_ERR;
      PH_DONE:    st_next.phase = PH_DONE;
      default:    st_next.phase = PH_ERR;
    endcase

    if (st_next.phase == PH_DONE) begin
      result.status = ST_COMPLETE;
    end else if (st_next.phase == PH_ERR) begin
      result.status = ST_MALFORMED;
    end else begin
      result.status = ST_BUSY;
    end

    if (body_last) begin
      result.status = (st_next.phase == PH_DONE) ? ST_COMPLETE : ST_MALFORMED;
      st_next       = ST_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

  // a last word always rearms the parser
  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    step && body_last |=> st.phase == PH_LEAD && !st.cp && !st.dseen)
    else $error("parser not rearmed after last word");

  // completion is sticky until the last word
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !body_last && st.phase == PH_DONE |=> st.phase == PH_DONE)
    else $error("completed body left done state");

  // data phase never holds a zero count
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_DATA |-> st.rem != '0)
    else $error("data phase with zero remaining count");

endmodule

// ----- src/chunked_body_decoder_core.sv -----
// top level of the chunked transfer body decoder
`timescale 1ns / 1ps

// chunked body decoder
// input channel s_*: one raw byte of a chunk-encoded body per word, s_tlast on
// the final byte of a body. output channel m_*: exactly one word per input word,
// carrying a decoded payload byte (m_tuser high) and the running decode status
// (0 in progress, 1 body complete, 2 malformed or truncated).
// a word accepted into the input register is decoded by the parse step and its
// result is registered in the output register, which drives m_*.
// throughput: one word per clock while m_tready does not stall the output, set by
// the combinational parse step between the input register and the output register;
// s_tready stays high while the output register can drain.
// size lines, hex parsing and crlf checks all run in the parse step on one byte.
// when m_tready is low the finished word waits in the output register while one
// more word is taken into the input register; only then does s_tready drop.
// reset clears both registers and returns the parser to the start of a size
// line; s_tlast does the same for the parser after its word is decoded.
module chunked_body_decoder_core #(
  parameter int SIZE_WIDTH = cbd_pkg::SIZE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] body_byte
  input  logic        s_tlast,   // body_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] payload_byte, [9:8] decode_status, rest zero
  output logic        m_tuser    // payload_valid
);
  import cbd_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // output register
  logic        out_valid;
  cbd_result_t out_res;

  cbd_result_t step_res;
  logic        advance;

  // move the held word through the parser when the output side has room
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  cbd_parser #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .body_byte(in_byte),
    .body_last(in_last),
    .result   (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.valid;
  assign m_tdata  = {6'b0, out_res.status, out_res.data};

  // every decoded word lands in the output register
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("decoded word not presented");

  // non-payload words carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> out_res.data == 8'h00)
    else $error("nonzero byte on non-payload word");

  // a payload byte is never reported alongside completion
  a_payload_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> out_res.status != ST_COMPLETE)
    else $error("payload byte with complete status");

  // a blocked input word is kept
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("held input word lost");

endmodule
